// ===== design/dmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int FREQ_W = 32;
  localparam int STR_W  = 12;
  localparam int DUR_W  = 32;
  localparam int TOL_W  = 24;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5000);

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [FREQ_W-1:0]       frequency_hz;
    logic signed [STR_W-1:0] strength;
    logic [DUR_W-1:0]        dwell_ms;
  } in_t;

  typedef struct packed {
    logic [3:0]              slot;
    logic                    merged;
    logic                    evicted;
    logic signed [STR_W-1:0] entry_strength;
    logic [DUR_W-1:0]        entry_dwell_ms;
    logic [4:0]              entry_count;
  } out_t;

  typedef struct packed {
    logic [FREQ_W-1:0]       freq;
    logic signed [STR_W-1:0] strength;
    logic [DUR_W-1:0]        dur;
  } entry_t;

  // search beat walking down the cell row
  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [IDX_W-1:0]        slot;
    logic [FREQ_W-1:0]       freq;
    logic signed [STR_W-1:0] strength;
    logic [DUR_W-1:0]        dur;
    logic signed [STR_W-1:0] res_strength;
    logic [DUR_W-1:0]        res_dur;
  } tok_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/dmt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmt_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire logic [dmt_pkg::IDX_W-1:0] idx,
  input  wire logic [dmt_pkg::CNT_W-1:0] count,
  input  wire logic [dmt_pkg::TOL_W-1:0] tol,
  input  wire dmt_pkg::cell_ctrl_t   ctrl,
  input  wire dmt_pkg::entry_t       load_data,
  input  wire dmt_pkg::entry_t       upper,
  output dmt_pkg::entry_t            ent,
  input  wire dmt_pkg::tok_t         tok_in,
  output dmt_pkg::tok_t              tok_out
);
  import dmt_pkg::*;

  entry_t                  ent_r, ent_nxt;
  tok_t                    tok_r, tok_nxt;
  logic [FREQ_W-1:0]       diff;
  logic                    live;
  logic                    match;
  logic [DUR_W:0]          sum;
  logic [DUR_W-1:0]        sat_dur;
  logic signed [STR_W-1:0] max_str;

  always_comb begin
    diff    = (ent_r.freq > tok_in.freq) ? (ent_r.freq - tok_in.freq)
                                         : (tok_in.freq - ent_r.freq);
    live    = {1'b0, idx} < (IDX_W + 1)'(count);
    match   = tok_in.valid && !tok_in.found && live &&
              (diff <= {{(FREQ_W - TOL_W){1'b0}}, tol});
    sum     = {1'b0, ent_r.dur} + {1'b0, tok_in.dur};
    sat_dur = sum[DUR_W] ? {DUR_W{1'b1}} : sum[DUR_W-1:0];
    max_str = (tok_in.strength > ent_r.strength) ? tok_in.strength : ent_r.strength;
  end

  always_comb begin
    ent_nxt = ent_r;
    tok_nxt = tok_in;
    if (ctrl.load) begin
      ent_nxt = load_data;
    end else if (ctrl.shift) begin
      ent_nxt = upper;
    end else if (match) begin
      ent_nxt.strength = max_str;
      ent_nxt.dur      = sat_dur;
    end
    if (match) begin
      tok_nxt.found        = 1'b1;
      tok_nxt.slot         = idx;
      tok_nxt.res_strength = max_str;
      tok_nxt.res_dur      = sat_dur;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign ent     = ent_r;
  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== design/detection_merge_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keeps an age-ordered list of up to MAX_ENTRIES detections in a row of cells,
// one entry per cell. An add beat walks the row one cell per cycle; busy rises
// after start and falls as out_valid strobes, so the next start may follow at
// once. A clear beat empties the table, shows its result in the cycle after
// start and never raises busy. out_valid is high for a single cycle per result
// and does not wait, since the receiver cannot stall; out_data keeps the value
// until the next result. cfg_we may only be used while busy is low.
module detection_merge_table_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire dmt_pkg::in_t    in_data,
  output logic                 out_valid,
  output dmt_pkg::out_t        out_data,
  input  wire                  cfg_we,
  input  wire logic [dmt_pkg::TOL_W-1:0] cfg_wdata
);
  import dmt_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOL_W-1:0] tol_r;
  tok_t             tok0_r, tok0_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  tok_t       tok [MAX_ENTRIES+1];
  entry_t     ent [MAX_ENTRIES+1];
  cell_ctrl_t ctrl [MAX_ENTRIES];

  logic   accept;
  logic   finish;
  logic   full;
  tok_t   last;
  entry_t new_ent;

  assign accept  = start && !busy_r;
  assign last    = tok[MAX_ENTRIES];
  assign finish  = last.valid;
  assign full    = (count_r == CNT_W'(MAX_ENTRIES));
  assign new_ent = '{freq: last.freq, strength: last.strength, dur: last.dur};

  assign tok[0]           = tok0_r;
  assign ent[MAX_ENTRIES] = new_ent;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    always_comb begin
      ctrl[k].shift = finish && !last.found && full;
      ctrl[k].load  = finish && !last.found && !full && (count_r == CNT_W'(k));
    end

    dmt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(k)),
      .count     (count_r),
      .tol       (tol_r),
      .ctrl      (ctrl[k]),
      .load_data (new_ent),
      .upper     (ent[k+1]),
      .ent       (ent[k]),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1])
    );
  end

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    tok0_nxt              = '0;
    tok0_nxt.valid        = accept && (in_data.kind == KIND_ADD);
    tok0_nxt.freq         = in_data.frequency_hz;
    tok0_nxt.strength     = in_data.strength;
    tok0_nxt.dur          = in_data.dwell_ms;

    if (accept) begin
      if (in_data.kind == KIND_CLEAR) begin
        count_nxt     = '0;
        out_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end

    if (finish) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (last.found) begin
        out_nxt.slot              = 4'(last.slot);
        out_nxt.merged            = 1'b1;
        out_nxt.evicted           = 1'b0;
        out_nxt.entry_strength    = last.res_strength;
        out_nxt.entry_dwell_ms    = last.res_dur;
        out_nxt.entry_count       = 5'(count_r);
      end else begin
        out_nxt.merged            = 1'b0;
        out_nxt.entry_strength    = last.strength;
        out_nxt.entry_dwell_ms    = last.dur;
        if (full) begin
          // oldest entry drops out, the row shifts down, new one lands on top
          out_nxt.slot        = 4'(MAX_ENTRIES - 1);
          out_nxt.evicted     = 1'b1;
          out_nxt.entry_count = 5'(count_r);
        end else begin
          out_nxt.slot        = 4'(count_r[IDX_W-1:0]);
          out_nxt.evicted     = 1'b0;
          count_nxt           = count_r + CNT_W'(1);
          out_nxt.entry_count = 5'(count_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      tol_r        <= TOL_RESET;
      tok0_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      tok0_r      <= tok0_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
